// ----- hw/rtl/mpq_pkg.sv -----
package mpq_pkg;

  // Action codes carried on the input channel.
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // Status codes returned with every result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;       // capture the accepted input item
    logic       clear_res;   // zero the result and set its status
    logic [1:0] res_status;
    logic       write_enq;   // append the captured entry, count up
    logic       scan_start;  // read entry zero
    logic       scan_step;   // compare the read entry, read the next one
    logic       shift_rd;    // read the entry above the gap
    logic       shift_wr;    // write it into the gap, move the gap up
    logic       dec_count;   // count down after a removal
    logic       load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] act;
    logic       empty;
    logic       full;
    logic       scan_last;
    logic       shift_last;
    logic       out_free;
  } stat_t;

endpackage

// ----- hw/rtl/max_priority_queue.sv -----
// Each item is captured, decided on, and its result loaded into the output register; a peek or a
// dequeue first scans all N held entries, and a dequeue then moves each entry above the best one down.
// Only one item is at work at a time; the load of a result waits until the output register is free.
// The next item is taken as soon as its result is in the output register.
// Reset (rst_ni, asynchronous, active low) empties the queue and drops any pending result.
// The entry memory itself is not cleared; only entries below the count are ever used.
module max_priority_queue #(
  parameter int DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [31:0] item_priority_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_value_o,
  output logic signed [31:0] out_priority_o,
  output logic [1:0]         status_o,
  output logic [7:0]         entry_count_o
);

  // The controller sequences each item: capture, decide, then either append, or scan the
  // held entries for the oldest highest priority and, on a dequeue, close the gap one entry
  // at a time. The datapath holds the entry memory, the count and the result registers.
  mpq_pkg::cmd_t  cmd;
  mpq_pkg::stat_t stat;

  mpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The output register separates the result from the input side, so a result waiting to be
  // taken does not stall the next item beyond its own final load.
  mpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (action_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o)
  );

`ifndef ASSERT_OFF
  // Only one item is in flight: an accepted item closes the input until its result is loaded.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is still at work");

  // A full queue refuses the entry and reports no entry.
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mpq_pkg::ST_FULL |-> out_value_o == 0 && out_priority_o == 0)
    else $error("full status with a non-zero entry");

  // An empty report can only come with an empty queue.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mpq_pkg::ST_EMPTY |-> entry_count_o == 8'd0)
    else $error("empty status with entries held");
`endif

endmodule

// ----- hw/rtl/mpq_dp.sv -----
module mpq_dp #(
  parameter int DEPTH = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpq_pkg::cmd_t       cmd_i,
  output mpq_pkg::stat_t      stat_o,
  input  logic [1:0]          action_i,
  input  logic signed [31:0]  item_value_i,
  input  logic signed [31:0]  item_priority_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  out_value_o,
  output logic signed [31:0]  out_priority_o,
  output logic [1:0]          status_o,
  output logic [7:0]          entry_count_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Each entry holds the value in the upper half and the priority in the lower half.
  logic [63:0]          mem_q [DEPTH];
  logic [63:0]          rdata_q;

  logic [1:0]           act_q;
  logic [31:0]          val_q;
  logic [31:0]          prio_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        count_d;
  logic [IW-1:0]        cmp_idx_q;
  logic [IW-1:0]        best_idx_q;
  logic [31:0]          res_value_q;
  logic [31:0]          res_prio_q;
  logic [1:0]           res_status_q;
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic [31:0]          out_value_q;
  logic [31:0]          out_prio_q;
  logic [1:0]           out_status_q;
  logic [7:0]           out_count_q;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [63:0]          mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic                 take;

  // A new best is taken only on a strictly greater priority, so the oldest wins a tie.
  assign take = (cmp_idx_q == '0) ||
                ($signed(rdata_q[31:0]) > $signed(res_prio_q));

  always_comb begin
    mem_we    = cmd_i.write_enq | cmd_i.shift_wr;
    mem_waddr = cmd_i.write_enq ? count_q[IW-1:0] : best_idx_q;
    mem_wdata = cmd_i.write_enq ? {val_q, prio_q} : rdata_q;
    mem_re    = cmd_i.scan_start | cmd_i.scan_step | cmd_i.shift_rd;
    if (cmd_i.scan_start) begin
      mem_raddr = '0;
    end else if (cmd_i.scan_step) begin
      mem_raddr = cmp_idx_q + IW'(1);
    end else begin
      mem_raddr = best_idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.write_enq) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      val_q  <= item_value_i;
      prio_q <= item_priority_i;
    end
    if (cmd_i.clear_res) begin
      res_value_q  <= '0;
      res_prio_q   <= '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.scan_start) begin
      cmp_idx_q <= '0;
    end
    if (cmd_i.scan_step) begin
      cmp_idx_q <= cmp_idx_q + IW'(1);
      if (take) begin
        res_value_q <= rdata_q[63:32];
        res_prio_q  <= rdata_q[31:0];
        best_idx_q  <= cmp_idx_q;
      end
    end
    if (cmd_i.shift_wr) begin
      best_idx_q <= best_idx_q + IW'(1);
    end
    if (cmd_i.load_out) begin
      out_value_q  <= res_value_q;
      out_prio_q   <= res_prio_q;
      out_status_q <= res_status_q;
      out_count_q  <= 8'(count_q);
    end
  end

  always_comb begin
    stat_o.act        = act_q;
    stat_o.empty      = (count_q == '0);
    stat_o.full       = (count_q == CW'(DEPTH));
    stat_o.scan_last  = (CW'(cmp_idx_q) == count_q - CW'(1));
    stat_o.shift_last = (CW'(best_idx_q) + CW'(1) >= count_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_prio_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = out_count_q;

endmodule

// ----- hw/rtl/mpq_ctrl.sv -----
module mpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpq_pkg::stat_t  stat_i,
  output mpq_pkg::cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_RESP     = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.clear_res  = 1'b1;
        cmd_o.res_status = mpq_pkg::ST_OK;
        state_d          = S_RESP;
        if (stat_i.act == mpq_pkg::ACT_ENQ) begin
          if (stat_i.full) begin
            cmd_o.res_status = mpq_pkg::ST_FULL;
          end else begin
            cmd_o.write_enq = 1'b1;
          end
        end else if (stat_i.act inside {mpq_pkg::ACT_DEQ, mpq_pkg::ACT_PEEK}) begin
          if (stat_i.empty) begin
            cmd_o.res_status = mpq_pkg::ST_EMPTY;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = (stat_i.act == mpq_pkg::ACT_DEQ) ? S_SHIFT_RD : S_RESP;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_last) begin
          cmd_o.dec_count = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- verif/tb.sv -----
module tb;

  // The block decodes four action codes; the package names three of them.
  // The fourth is a no-operation that still returns a result item.
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int QUEUE_DEPTH = 128;
  // The slowest item is a dequeue from a full queue whose best entry is the
  // oldest: about three passes over the store.
  localparam int SLOWEST_ITEM = 3 * QUEUE_DEPTH + 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 500;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // One result item as the block should return it.
  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] prio;
    logic [1:0]         status;
    logic [7:0]         count;
  } queue_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic signed [31:0] item_value_i;
  logic signed [31:0] item_priority_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_value_o;
  logic signed [31:0] out_priority_o;
  logic [1:0]         status_o;
  logic [7:0]         entry_count_o;

  // Shadow copy of the queue contents, oldest entry at index zero.
  logic signed [31:0] held_values[$];
  logic signed [31:0] held_prios[$];
  // Result items still owed by the block, oldest first.
  queue_result_t      owed_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  random_sent = 0;
  // When clear, neither side of the block idles or stalls.
  bit  idling_on = 1'b1;

  max_priority_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  // A hung handshake must not stall the run for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls in roughly a quarter of the cycles while idling is on.
  always @(posedge clk_i) begin
    if (idling_on) begin
      out_ready_i <= ($urandom_range(99) >= 23);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Applies one accepted item to the shadow queue and records the result item
  // it must produce. The best entry is the first one holding the greatest
  // priority, so on a tie the oldest entry is served.
  function automatic void predict_queue_op(input logic [1:0] act,
                                           input logic signed [31:0] val,
                                           input logic signed [31:0] pri);
    queue_result_t res;
    int            best;
    res.value  = '0;
    res.prio   = '0;
    res.status = mpq_pkg::ST_OK;
    case (act)
      mpq_pkg::ACT_ENQ: begin
        if (held_values.size() >= QUEUE_DEPTH) begin
          res.status = mpq_pkg::ST_FULL;
        end else begin
          held_values.push_back(val);
          held_prios.push_back(pri);
        end
      end
      mpq_pkg::ACT_DEQ, mpq_pkg::ACT_PEEK: begin
        if (held_values.size() == 0) begin
          res.status = mpq_pkg::ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held_values.size(); i++) begin
            if (held_prios[i] > held_prios[best]) best = i;
          end
          res.value = held_values[best];
          res.prio  = held_prios[best];
          if (act == mpq_pkg::ACT_DEQ) begin
            held_values.delete(best);
            held_prios.delete(best);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = 8'(held_values.size());
    owed_results.push_back(res);
  endfunction

  // Every result item taken by the receiver is matched against the oldest
  // owed one, field by field.
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, value", out_value_o, '0);
      end else begin
        want = owed_results.pop_front();
        if (out_value_o !== want.value)
          report_mismatch("value", out_value_o, want.value);
        if (out_priority_o !== want.prio)
          report_mismatch("priority", out_priority_o, want.prio);
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (entry_count_o !== want.count)
          report_mismatch("entry count", 32'(entry_count_o), 32'(want.count));
      end
    end
  end

  // Presents one item and returns in the time step of the edge that accepts
  // it. Valid is left high there, so the next item can follow at once; any
  // caller that lets time pass afterwards lowers it first.
  task automatic send_item(input logic [1:0] act, input logic signed [31:0] val,
                           input logic signed [31:0] pri);
    while (idling_on && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    item_value_i    <= val;
    item_priority_i <= pri;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_queue_op(act, val, pri);
  endtask

  // Stops sending and holds off until the block owes nothing.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Priorities are drawn so that ties and both signed extremes turn up often.
  function automatic logic signed [31:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return $urandom;
    if (roll < 80) return $signed(32'($urandom_range(7))) - 32'sd4;
    case ($urandom_range(3))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // Draws an action with the given percentage of enqueues; the rest is mostly
  // dequeues, then peeks, with the odd no-operation.
  function automatic logic [1:0] pick_action(input int enq_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < enq_pct) return mpq_pkg::ACT_ENQ;
    roll = $urandom_range(99);
    if (roll < 70) return mpq_pkg::ACT_DEQ;
    if (roll < 94) return mpq_pkg::ACT_PEEK;
    return ACT_NOP;
  endfunction

  task automatic send_random(input int enq_pct);
    send_item(pick_action(enq_pct), $urandom, pick_priority());
    random_sent++;
  endtask

  // Peek, dequeue and no-operation on an empty queue, then one entry in and
  // out again.
  task automatic test_empty_queue();
    send_item(mpq_pkg::ACT_PEEK, $urandom, $urandom);
    send_item(mpq_pkg::ACT_DEQ, $urandom, $urandom);
    send_item(ACT_NOP, $urandom, $urandom);
    send_item(mpq_pkg::ACT_ENQ, 32'sd5, 32'sd1);
    send_item(mpq_pkg::ACT_DEQ, $urandom, $urandom);
    send_item(mpq_pkg::ACT_DEQ, $urandom, $urandom);
  endtask

  // Both signed extremes in value and priority. The second entry with the
  // top priority must wait for the first, and the lowest priority goes last.
  task automatic test_extreme_fields();
    send_item(mpq_pkg::ACT_ENQ, S32_MAX, S32_MIN);
    send_item(mpq_pkg::ACT_ENQ, S32_MIN, S32_MAX);
    send_item(mpq_pkg::ACT_ENQ, -32'sd1, -32'sd1);
    send_item(mpq_pkg::ACT_ENQ, 32'sd0, 32'sd0);
    send_item(mpq_pkg::ACT_ENQ, 32'sh5555_aaaa, S32_MAX);
    send_item(mpq_pkg::ACT_PEEK, $urandom, $urandom);
    send_item(ACT_NOP, $urandom, $urandom);
    repeat (6) send_item(mpq_pkg::ACT_DEQ, $urandom, $urandom);
  endtask

  // Equal priorities are served in arrival order.
  task automatic test_equal_priorities();
    send_item(mpq_pkg::ACT_ENQ, 32'sd1, 32'sd7);
    send_item(mpq_pkg::ACT_ENQ, 32'sd2, 32'sd7);
    send_item(mpq_pkg::ACT_ENQ, 32'sd3, 32'sd7);
    send_item(mpq_pkg::ACT_PEEK, $urandom, $urandom);
    repeat (3) send_item(mpq_pkg::ACT_DEQ, $urandom, $urandom);
  endtask

  // Fills the queue with random entries, pushes against the full queue, and
  // then drains it with a dequeue-heavy mix until it is empty.
  task automatic test_full_queue();
    while (held_values.size() < QUEUE_DEPTH) send_random(90);
    repeat (3) begin
      send_item(mpq_pkg::ACT_ENQ, $urandom, pick_priority());
      random_sent++;
    end
    send_item(mpq_pkg::ACT_PEEK, $urandom, $urandom);
    send_item(ACT_NOP, $urandom, $urandom);
    random_sent += 2;
    while (held_values.size() > 0) send_random(12);
    // The sender holds off here until the block has caught up completely.
    wait_for_results();
  endtask

  // Random mix in phases that swing between filling and draining. The first
  // stretch runs with no idling on either side.
  task automatic test_random_mix();
    int phase_len;
    int enq_pct;
    idling_on = 1'b0;
    repeat (80) send_random(55);
    idling_on = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 40);
      case ($urandom_range(2))
        0:       enq_pct = 80;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      repeat (phase_len) send_random(enq_pct);
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_NOP;
    item_value_i    <= '0;
    item_priority_i <= '0;
    out_ready_i     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_extreme_fields();
    test_equal_priorities();
    wait_for_results();
    test_full_queue();
    test_random_mix();

    // Let the last items through, then watch a while longer for stray results.
    wait_for_results();
    repeat (SLOWEST_ITEM) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- max_priority_queue.f -----
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_dp.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/max_priority_queue.sv
verif/tb.sv
